@@ rtl/trcd_pkg.sv @@
// Package for the tile reorder / centre distance unit.
// Field widths, register indexes, packing offsets and default sizes.
// No dependencies.
package trcd_pkg;

  localparam int MAX_TILE_DEF           = 64;
  localparam int MAX_TILES_PER_SIDE_DEF = 1024;

  localparam int TILE_SIZE_RST = 8;

  localparam int TILE_SIZE_W   = 7;
  localparam int TILES_SIDE_W  = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_INDEX_W   = 2;

  localparam int VEL_W          = 32;
  localparam int TILE_NUMBER_W  = 20;
  localparam int POINT_W        = 12;
  localparam int DIST_W         = 13;
  localparam int TILE_COUNT_W   = 21;

  localparam int IN_TDATA_W  = 2 * VEL_W;
  localparam int OUT_FIELDS_W = TILE_NUMBER_W + POINT_W + 2 * VEL_W + DIST_W + TILE_COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TILE_SIZE    = 2'd0,
    CFG_TILES_ACROSS = 2'd1,
    CFG_TILES_DOWN   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  // Zero reads as one, anything above hi saturates to hi.
  function automatic int clamp_reg(input logic [CFG_DATA_W-1:0] v, input int hi);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

@@ rtl/tile_reorder_with_center_distance_unit.sv @@
// Raster-to-tile address generator with tile-centre distance.
// Result registered the cycle after input; 1 beat per cycle while out_tready is high.
// One register stage: position counters feed small multipliers into the output register.
// rst_n (synchronous, active low) restores tile_size 8, 1 x 1 tiles, counters zero.
// A write to a used config index also restarts the frame at its first point.
module tile_reorder_with_center_distance_unit #(
  parameter int MAX_TILE           = trcd_pkg::MAX_TILE_DEF,
  parameter int MAX_TILES_PER_SIDE = trcd_pkg::MAX_TILES_PER_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0: vel_x_bits[31:0], vel_y_bits[31:0]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [trcd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata, from bit 0: tile_number[19:0], point_in_tile[11:0], out_vel_x[31:0],
  // out_vel_y[31:0], center_dist_quarters[12:0], tile_count[20:0], zero pad[5:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [trcd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,   // frame_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [trcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [trcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trcd_pkg::*;

  localparam int CW = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int LW = $clog2(MAX_TILE + 1);
  localparam int TW = (MAX_TILES_PER_SIDE > 1) ? $clog2(MAX_TILES_PER_SIDE) : 1;
  localparam int AW = $clog2(MAX_TILES_PER_SIDE + 1);
  localparam int TileRst = (TILE_SIZE_RST > MAX_TILE) ? MAX_TILE : TILE_SIZE_RST;
  localparam int DW = LW + 2;
  localparam int SW = 2 * DW;
  localparam int PadW = OUT_TDATA_W - OUT_FIELDS_W;

  logic [LW-1:0] tile_size_r;
  logic [AW-1:0] tiles_across_r;
  logic [AW-1:0] tiles_down_r;

  logic [CW-1:0] col_in_tile_r, col_in_tile_nxt;
  logic [TW-1:0] tile_col_r,    tile_col_nxt;
  logic [CW-1:0] row_in_tile_r, row_in_tile_nxt;
  logic [TW-1:0] tile_row_r,    tile_row_nxt;

  logic                     out_valid_r;
  logic [TILE_NUMBER_W-1:0] tile_number_r, tile_number_nxt;
  logic [POINT_W-1:0]       point_r,       point_nxt;
  logic [VEL_W-1:0]         vel_x_r, vel_y_r;
  logic [DIST_W-1:0]        dist_r,        dist_nxt;
  logic [TILE_COUNT_W-1:0]  count_r,       count_nxt;
  logic                     last_r,        frame_last_nxt;

  logic in_acc, cfg_acc;
  logic last_col, last_tcol, last_row, last_trow;
  logic signed [DW-1:0] d_col, d_row;
  logic signed [SW-1:0] sq_col, sq_row;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;

  always_comb begin
    last_col  = ((LW+1)'(col_in_tile_r) + 1'b1) >= (LW+1)'(tile_size_r);
    last_tcol = ((AW+1)'(tile_col_r) + 1'b1)    >= (AW+1)'(tiles_across_r);
    last_row  = ((LW+1)'(row_in_tile_r) + 1'b1) >= (LW+1)'(tile_size_r);
    last_trow = ((AW+1)'(tile_row_r) + 1'b1)    >= (AW+1)'(tiles_down_r);
    frame_last_nxt = last_col && last_tcol && last_row && last_trow;

    col_in_tile_nxt = col_in_tile_r;
    tile_col_nxt    = tile_col_r;
    row_in_tile_nxt = row_in_tile_r;
    tile_row_nxt    = tile_row_r;
    if (!last_col) begin
      col_in_tile_nxt = col_in_tile_r + 1'b1;
    end else begin
      col_in_tile_nxt = '0;
      if (!last_tcol) begin
        tile_col_nxt = tile_col_r + 1'b1;
      end else begin
        tile_col_nxt = '0;
        if (!last_row) begin
          row_in_tile_nxt = row_in_tile_r + 1'b1;
        end else begin
          row_in_tile_nxt = '0;
          tile_row_nxt    = last_trow ? '0 : tile_row_r + 1'b1;
        end
      end
    end

    tile_number_nxt = TILE_NUMBER_W'(tile_row_r * tiles_across_r + (TW+AW)'(tile_col_r));
    point_nxt       = POINT_W'(row_in_tile_r * tile_size_r + (CW+LW)'(col_in_tile_r));
    count_nxt       = TILE_COUNT_W'(tiles_across_r * tiles_down_r);

    d_col  = $signed(DW'({col_in_tile_r, 1'b0})) - $signed(DW'(tile_size_r - 1'b1));
    d_row  = $signed(DW'({row_in_tile_r, 1'b0})) - $signed(DW'(tile_size_r - 1'b1));
    sq_col = SW'(d_col * d_col);
    sq_row = SW'(d_row * d_row);
    dist_nxt = DIST_W'(sq_col + sq_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r    <= LW'(TileRst);
      tiles_across_r <= AW'(1);
      tiles_down_r   <= AW'(1);
      col_in_tile_r  <= '0;
      tile_col_r     <= '0;
      row_in_tile_r  <= '0;
      tile_row_r     <= '0;
      out_valid_r    <= 1'b0;
      last_r         <= 1'b0;
    end else begin
      if (cfg_acc && cfg_index != CFG_UNUSED) begin
        case (cfg_index)
          CFG_TILE_SIZE: begin
            tile_size_r <= LW'(clamp_reg(CFG_DATA_W'(cfg_data[TILE_SIZE_W-1:0]), MAX_TILE));
          end
          CFG_TILES_ACROSS: begin
            tiles_across_r <= AW'(clamp_reg(cfg_data, MAX_TILES_PER_SIDE));
          end
          CFG_TILES_DOWN: begin
            tiles_down_r <= AW'(clamp_reg(cfg_data, MAX_TILES_PER_SIDE));
          end
          default: begin
          end
        endcase
        col_in_tile_r <= '0;
        tile_col_r    <= '0;
        row_in_tile_r <= '0;
        tile_row_r    <= '0;
      end else if (in_acc) begin
        col_in_tile_r <= col_in_tile_nxt;
        tile_col_r    <= tile_col_nxt;
        row_in_tile_r <= row_in_tile_nxt;
        tile_row_r    <= tile_row_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
        last_r      <= frame_last_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tile_number_r <= tile_number_nxt;
      point_r       <= point_nxt;
      vel_x_r       <= in_tdata[VEL_W-1:0];
      vel_y_r       <= in_tdata[2*VEL_W-1:VEL_W];
      dist_r        <= dist_nxt;
      count_r       <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {PadW'(0), count_r, dist_r, vel_y_r, vel_x_r, point_r, tile_number_r};

`ifndef NO_ASSERTIONS
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (LW+1)'(col_in_tile_r) < (LW+1)'(tile_size_r))
    else $error("column in tile out of range");

  a_tcol_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(tile_col_r) < (AW+1)'(tiles_across_r))
    else $error("tile column out of range");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    tile_size_r != '0 && (LW+1)'(tile_size_r) <= (LW+1)'(MAX_TILE))
    else $error("tile size outside legal range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_last_nxt && !cfg_acc) |=>
      (col_in_tile_r == '0 && tile_col_r == '0 && row_in_tile_r == '0 && tile_row_r == '0))
    else $error("counters did not wrap after last point of frame");
`endif

endmodule
